FILE: rtl/tlvfc_pkg.sv
// Package for the TLV frame checker: frame layout constants, status codes
// and the byte-wide CRC-16/MODBUS update. No dependencies.
package tlvfc_pkg;

  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned LENGTH_BITS  = 16;
  localparam int unsigned COUNT_BITS   = LENGTH_BITS + 1;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;
  localparam logic [15:0]            CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]            CRC_POLY  = 16'hA001;

  // header byte positions
  localparam logic [COUNT_BITS-1:0] IDX_MAGIC_LO = COUNT_BITS'(0);
  localparam logic [COUNT_BITS-1:0] IDX_MAGIC_HI = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] IDX_VERSION  = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0] IDX_LEN_LO   = COUNT_BITS'(3);
  localparam logic [COUNT_BITS-1:0] IDX_LEN_HI   = COUNT_BITS'(4);
  localparam logic [COUNT_BITS-1:0] IDX_TYPE     = COUNT_BITS'(HEADER_BYTES - 1);
  // first index whose arrival releases a value byte (header plus one held)
  localparam logic [COUNT_BITS-1:0] IDX_FIRST_VALUE = COUNT_BITS'(HEADER_BYTES + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_LEN_BAD  = 2'd2,
    ST_CRC_BAD  = 2'd3
  } frame_status_t;

  typedef enum logic {
    KIND_VALUE  = 1'b0,
    KIND_STATUS = 1'b1
  } item_kind_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/tlv_frame_checker_crc16_unit.sv
// Streaming TLV frame checker with CRC-16/MODBUS trailer check.
// Depends on tlvfc_pkg (layout constants, status codes, crc_byte).
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | data_byte, last_byte
//  out_    | output    | out_valid/out_stall | item_kind, value_byte, status, header, crc
//
// One word accepted per cycle while in_stall is low; its result (if any)
// appears in the output register on the next cycle. The byte-wide CRC
// update sets the path length. in_stall is high only while a result waits
// in the output register and out_stall is high. rst_n is synchronous,
// active low, and returns frame state to the start of a frame.
module tlv_frame_checker_crc16_unit
  import tlvfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_item_kind,
  output logic [7:0]            out_value_byte,
  output logic [1:0]            out_frame_status,
  output logic [15:0]           out_frame_magic,
  output logic [7:0]            out_frame_version,
  output logic [LENGTH_BITS-1:0] out_declared_length,
  output logic [7:0]            out_frame_type,
  output logic [15:0]           out_received_crc
);

  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [15:0]            crc_r, crc_nxt;
  logic [7:0]             held0_r, held0_nxt, held1_r, held1_nxt;
  logic [15:0]            magic_r, magic_nxt, magic_cap;
  logic [7:0]             version_r, version_nxt, version_cap;
  logic [LENGTH_BITS-1:0] length_r, length_nxt, length_cap;
  logic [7:0]             type_r, type_nxt, type_cap;

  logic                   out_valid_r, out_valid_nxt;
  item_kind_t             kind_r, kind_nxt;
  logic [7:0]             value_r, value_nxt;
  frame_status_t          status_r, status_nxt;
  logic [15:0]            omagic_r, omagic_nxt;
  logic [7:0]             oversion_r, oversion_nxt;
  logic [LENGTH_BITS-1:0] olength_r, olength_nxt;
  logic [7:0]             otype_r, otype_nxt;
  logic [15:0]            ocrc_r, ocrc_nxt;

  logic                   accept, take, has_result;
  logic [15:0]            crc_upd, rx_crc;
  logic [COUNT_BITS:0]    frame_len;

  assign take     = out_valid_r & ~out_stall;
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    magic_cap   = magic_r;
    version_cap = version_r;
    length_cap  = length_r;
    type_cap    = type_r;
    case (count_r)
      IDX_MAGIC_LO: magic_cap[7:0]   = in_data_byte;
      IDX_MAGIC_HI: magic_cap[15:8]  = in_data_byte;
      IDX_VERSION:  version_cap      = in_data_byte;
      IDX_LEN_LO:   length_cap[7:0]  = in_data_byte;
      IDX_LEN_HI:   length_cap[15:8] = in_data_byte;
      IDX_TYPE:     type_cap         = in_data_byte;
      default: ;
    endcase
  end

  // fold the byte two positions back
  assign crc_upd   = (|count_r[COUNT_BITS-1:1]) ? crc_byte(crc_r, held0_r) : crc_r;
  assign rx_crc    = {in_data_byte, held1_r};
  assign frame_len = {1'b0, count_r} + (COUNT_BITS+1)'(1);

  always_comb begin
    count_nxt     = count_r;
    crc_nxt       = crc_r;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;
    magic_nxt     = magic_r;
    version_nxt   = version_r;
    length_nxt    = length_r;
    type_nxt      = type_r;
    has_result    = 1'b0;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    status_nxt    = status_r;
    omagic_nxt    = omagic_r;
    oversion_nxt  = oversion_r;
    olength_nxt   = olength_r;
    otype_nxt     = otype_r;
    ocrc_nxt      = ocrc_r;
    if (accept) begin
      if (in_last_byte) begin
        has_result   = 1'b1;
        kind_nxt     = KIND_STATUS;
        value_nxt    = 8'h00;
        omagic_nxt   = magic_cap;
        oversion_nxt = version_cap;
        olength_nxt  = length_cap;
        otype_nxt    = type_cap;
        ocrc_nxt     = rx_crc;
        if (count_r < IDX_FIRST_VALUE) begin
          status_nxt = ST_SHORT;
          ocrc_nxt   = 16'h0000;
        end else if (frame_len != {2'b00, length_cap}) begin
          status_nxt = ST_LEN_BAD;
        end else if (crc_upd != rx_crc) begin
          status_nxt = ST_CRC_BAD;
        end else begin
          status_nxt = ST_OK;
        end
        count_nxt   = '0;
        crc_nxt     = CRC_INIT;
        held0_nxt   = 8'h00;
        held1_nxt   = 8'h00;
        magic_nxt   = 16'h0000;
        version_nxt = 8'h00;
        length_nxt  = '0;
        type_nxt    = 8'h00;
      end else begin
        if (count_r >= IDX_FIRST_VALUE) begin
          has_result   = 1'b1;
          kind_nxt     = KIND_VALUE;
          value_nxt    = held1_r;
          status_nxt   = ST_OK;
          omagic_nxt   = 16'h0000;
          oversion_nxt = 8'h00;
          olength_nxt  = '0;
          otype_nxt    = 8'h00;
          ocrc_nxt     = 16'h0000;
        end
        crc_nxt     = crc_upd;
        held0_nxt   = held1_r;
        held1_nxt   = in_data_byte;
        magic_nxt   = magic_cap;
        version_nxt = version_cap;
        length_nxt  = length_cap;
        type_nxt    = type_cap;
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = has_result;
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= CRC_INIT;
      held0_r     <= 8'h00;
      held1_r     <= 8'h00;
      magic_r     <= 16'h0000;
      version_r   <= 8'h00;
      length_r    <= '0;
      type_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      held0_r     <= held0_nxt;
      held1_r     <= held1_nxt;
      magic_r     <= magic_nxt;
      version_r   <= version_nxt;
      length_r    <= length_nxt;
      type_r      <= type_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (has_result) begin
      kind_r     <= kind_nxt;
      value_r    <= value_nxt;
      status_r   <= status_nxt;
      omagic_r   <= omagic_nxt;
      oversion_r <= oversion_nxt;
      olength_r  <= olength_nxt;
      otype_r    <= otype_nxt;
      ocrc_r     <= ocrc_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_item_kind       = kind_r;
  assign out_value_byte      = value_r;
  assign out_frame_status    = status_r;
  assign out_frame_magic     = omagic_r;
  assign out_frame_version   = oversion_r;
  assign out_declared_length = olength_r;
  assign out_frame_type      = otype_r;
  assign out_received_crc    = ocrc_r;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no word held");

  a_last_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (count_r == '0 && crc_r == CRC_INIT && out_valid_r))
    else $error("frame state not cleared after final byte");

  a_short_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_STATUS && status_r == ST_SHORT) |-> ocrc_r == 16'h0000)
    else $error("short frame reports a crc");

  a_value_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_VALUE) |-> (status_r == ST_OK && olength_r == '0))
    else $error("value word carries status fields");

  a_no_word_early: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_last_byte && count_r < IDX_FIRST_VALUE) |=> !out_valid_r)
    else $error("value word released inside header");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for tlv_frame_checker_crc16_unit: a directed table and random frames, every
// result word checked against a frame tracker or a typed table row. Depends on tlvfc_pkg.
module tb
  import tlvfc_pkg::*;
;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_WORDS = 400;

  typedef struct packed {
    item_kind_t    kind;
    logic [7:0]    value;
    frame_status_t status;
    logic [15:0]   magic;
    logic [7:0]    version;
    logic [15:0]   dlen;
    logic [7:0]    ftype;
    logic [15:0]   rcrc;
  } frame_item_t;

  typedef enum logic [1:0] {FIX_NONE, FIX_CRC_LO, FIX_CRC_HI} crc_fix_t;

  typedef enum logic [2:0] {FK_GOOD, FK_CRC_BAD, FK_LEN_BAD, FK_SHORT, FK_NOISE} frame_kind_t;

  typedef struct {
    logic [7:0]  b;
    logic        is_last;
    crc_fix_t    fix;
    bit          typed;
    frame_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_item_kind;
  logic [7:0]  out_value_byte;
  logic [1:0]  out_frame_status;
  logic [15:0] out_frame_magic;
  logic [7:0]  out_frame_version;
  logic [LENGTH_BITS-1:0] out_declared_length;
  logic [7:0]  out_frame_type;
  logic [15:0] out_received_crc;

  tlv_frame_checker_crc16_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_item_kind       (out_item_kind),
    .out_value_byte      (out_value_byte),
    .out_frame_status    (out_frame_status),
    .out_frame_magic     (out_frame_magic),
    .out_frame_version   (out_frame_version),
    .out_declared_length (out_declared_length),
    .out_frame_type      (out_frame_type),
    .out_received_crc    (out_received_crc)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame tracker state
  logic [COUNT_BITS-1:0] rx_count;
  logic [15:0]           rx_crc;
  logic [7:0]            hold_old, hold_new;
  logic [15:0]           hdr_magic, hdr_len;
  logic [7:0]            hdr_version, hdr_type;

  frame_item_t awaited_items[$];
  dir_row_t    dir_rows[$];

  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned results_seen = 0;
  int unsigned frames_sent = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic frame_item_t status_item(input frame_status_t st, input logic [15:0] magic,
                                              input logic [7:0] ver, input logic [15:0] dlen,
                                              input logic [7:0] ftype, input logic [15:0] rcrc);
    frame_item_t it;
    it = '0;
    it.kind = KIND_STATUS;
    it.status = st;
    it.magic = magic;
    it.version = ver;
    it.dlen = dlen;
    it.ftype = ftype;
    it.rcrc = rcrc;
    return it;
  endfunction

  function automatic frame_item_t value_item(input logic [7:0] b);
    frame_item_t it;
    it = '0;
    it.kind = KIND_VALUE;
    it.value = b;
    return it;
  endfunction

  task automatic clear_rx();
    rx_count = '0;
    rx_crc = CRC_INIT;
    hold_old = '0;
    hold_new = '0;
    hdr_magic = '0;
    hdr_len = '0;
    hdr_version = '0;
    hdr_type = '0;
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic is_last,
                                  output bit has_res, output frame_item_t res);
    int unsigned flen;
    logic [15:0] rcv;
    frame_status_t st;
    res = '0;
    has_res = 1'b0;
    case (rx_count)
      IDX_MAGIC_LO: hdr_magic[7:0] = b;
      IDX_MAGIC_HI: hdr_magic[15:8] = b;
      IDX_VERSION:  hdr_version = b;
      IDX_LEN_LO:   hdr_len[7:0] = b;
      IDX_LEN_HI:   hdr_len[15:8] = b;
      IDX_TYPE:     hdr_type = b;
      default: ;
    endcase
    if (rx_count >= 2) rx_crc = crc16_fold(rx_crc, hold_old);
    if (is_last) begin
      flen = int'(rx_count) + 1;
      rcv = {b, hold_new};
      if (flen < HEADER_BYTES + 2) begin
        st = ST_SHORT;
        rcv = '0;
      end else if (flen != int'(hdr_len)) begin
        st = ST_LEN_BAD;
      end else if (rx_crc != rcv) begin
        st = ST_CRC_BAD;
      end else begin
        st = ST_OK;
      end
      res = status_item(st, hdr_magic, hdr_version, hdr_len, hdr_type, rcv);
      has_res = 1'b1;
      clear_rx();
    end else begin
      if (rx_count >= IDX_FIRST_VALUE) begin
        res = value_item(hold_new);
        has_res = 1'b1;
      end
      hold_old = hold_new;
      hold_new = b;
      if (rx_count != COUNT_MAX) rx_count = rx_count + 1'b1;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic is_last, input bit typed,
                           input frame_item_t typed_want);
    int unsigned gap;
    bit has_res;
    frame_item_t res;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= is_last;
    do @(posedge clk); while (in_stall);
    words_in++;
    track_frame_byte(b, is_last, has_res, res);
    if (typed) awaited_items.insert(awaited_items.size(), typed_want);
    else if (has_res) awaited_items.insert(awaited_items.size(), res);
    if (is_last) frames_sent++;
  endtask

  task automatic add_row(input logic [7:0] b, input logic is_last, input crc_fix_t fix,
                         input bit typed, input frame_item_t want);
    dir_row_t row;
    row.b = b;
    row.is_last = is_last;
    row.fix = fix;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]  q[$];
    int unsigned n_val, n;
    logic [15:0] magic, dlen, crc;
    logic [7:0]  ver, ftype;
    q = {};
    n_val = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 40);
    magic = 16'($urandom);
    ver = 8'($urandom);
    ftype = 8'($urandom);
    if (kind == FK_SHORT || kind == FK_NOISE) begin
      n = (kind == FK_SHORT) ? $urandom_range(1, 7) : $urandom_range(1, 30);
      repeat (n) q.insert(q.size(), 8'($urandom));
    end else begin
      n = HEADER_BYTES + 2 + n_val;
      dlen = 16'(n);
      if (kind == FK_LEN_BAD) begin
        case ($urandom_range(0, 2))
          0: dlen = 16'(n + 1);
          1: dlen = 16'(n - 1);
          default: dlen = 16'($urandom);
        endcase
      end
      q.insert(q.size(), magic[7:0]);
      q.insert(q.size(), magic[15:8]);
      q.insert(q.size(), ver);
      q.insert(q.size(), dlen[7:0]);
      q.insert(q.size(), dlen[15:8]);
      q.insert(q.size(), ftype);
      repeat (n_val) q.insert(q.size(), 8'($urandom));
      crc = CRC_INIT;
      foreach (q[i]) crc = crc16_fold(crc, q[i]);
      if (kind == FK_CRC_BAD) crc = crc ^ 16'($urandom_range(1, 65535));
      q.insert(q.size(), crc[7:0]);
      q.insert(q.size(), crc[15:8]);
    end
    foreach (q[i]) send_word(q[i], i == q.size() - 1, 1'b0, '0);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: out_stall <= 1'b0;
        [70:94]: begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(0, 2);
        end
        default: begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(9, 39);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    frame_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_items.size() == 0) begin
        errors++;
        $display("%0t: result word with none awaited, expected nothing, got kind %0h", $time,
                 out_item_kind);
      end else begin
        w = awaited_items.pop_front();
        if (w.kind == KIND_STATUS) status_seen[w.status]++;
        cmp_field("item_kind", 16'(w.kind), 16'(out_item_kind));
        cmp_field("value_byte", 16'(w.value), 16'(out_value_byte));
        cmp_field("frame_status", 16'(w.status), 16'(out_frame_status));
        cmp_field("frame_magic", w.magic, out_frame_magic);
        cmp_field("frame_version", 16'(w.version), 16'(out_frame_version));
        cmp_field("declared_length", w.dlen, 16'(out_declared_length));
        cmp_field("frame_type", 16'(w.ftype), 16'(out_frame_type));
        cmp_field("received_crc", w.rcrc, out_received_crc);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] tx_acc, tx_hold;
    logic [7:0]  b;
    frame_kind_t kind;
    int unsigned r;
    clear_rx();
    tx_acc = CRC_INIT;
    tx_hold = CRC_INIT;

    // one-byte frame straight after reset
    add_row(8'hFF, 1'b1, FIX_NONE, 1'b1, status_item(ST_SHORT, 16'h00FF, 8'h00, 16'h0000,
                                                     8'h00, 16'h0000));
    // longest frame that is still too short
    for (int i = 0; i < 6; i++) add_row(8'h00, 1'b0, FIX_NONE, 1'b0, '0);
    add_row(8'h00, 1'b1, FIX_NONE, 1'b1, status_item(ST_SHORT, 16'h0000, 8'h00, 16'h0000,
                                                     8'h00, 16'h0000));
    // minimal good frame, all-ones header but for the length of 8
    add_row(8'hFF, 1'b0, FIX_NONE, 1'b0, '0);
    add_row(8'hFF, 1'b0, FIX_NONE, 1'b0, '0);
    add_row(8'hFF, 1'b0, FIX_NONE, 1'b0, '0);
    add_row(8'h08, 1'b0, FIX_NONE, 1'b0, '0);
    add_row(8'h00, 1'b0, FIX_NONE, 1'b0, '0);
    add_row(8'hFF, 1'b0, FIX_NONE, 1'b0, '0);
    add_row(8'h00, 1'b0, FIX_CRC_LO, 1'b0, '0);
    add_row(8'h00, 1'b1, FIX_CRC_HI, 1'b0, '0);
    // one value byte, header claims length zero
    for (int i = 0; i < 6; i++) add_row(8'h00, 1'b0, FIX_NONE, 1'b0, '0);
    add_row(8'hA5, 1'b0, FIX_NONE, 1'b0, '0);
    add_row(8'h00, 1'b0, FIX_NONE, 1'b1, value_item(8'hA5));
    add_row(8'h00, 1'b1, FIX_NONE, 1'b1, status_item(ST_LEN_BAD, 16'h0000, 8'h00, 16'h0000,
                                                     8'h00, 16'h0000));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      b = dir_rows[i].b;
      if (dir_rows[i].fix == FIX_CRC_LO) begin
        b = tx_acc[7:0];
        tx_hold = tx_acc;
      end else if (dir_rows[i].fix == FIX_CRC_HI) begin
        b = tx_hold[15:8];
      end
      tx_acc = dir_rows[i].is_last ? CRC_INIT : crc16_fold(tx_acc, b);
      send_word(b, dir_rows[i].is_last, dir_rows[i].typed, dir_rows[i].want);
    end

    // mostly well-formed frames, the rest broken or noise
    while (words_in < dir_rows.size() + RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 60) kind = FK_GOOD;
      else if (r < 70) kind = FK_CRC_BAD;
      else if (r < 80) kind = FK_LEN_BAD;
      else if (r < 90) kind = FK_SHORT;
      else kind = FK_NOISE;
      quiet = ($urandom_range(0, 7) == 0);
      send_frame(kind);
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Drove %0d frames in %0d words: good, broken and noise frames, random stalls;",
             frames_sent, words_in);
    $display("checked %0d result words: status ok %0d, short %0d, length %0d, crc %0d.",
             results_seen, status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_LEN_BAD],
             status_seen[ST_CRC_BAD]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
